// ----- src/leb_pkg.sv -----
// Shared types and constants for the LEB128 encoder.
package leb_pkg;

    localparam int VALUE_W   = 64;
    localparam int GROUP_W   = 7;
    localparam int MAX_BYTES = 10;
    localparam int CNT_W     = $clog2(MAX_BYTES);

    localparam logic [1:0] OP_U32 = 2'd0;
    localparam logic [1:0] OP_U64 = 2'd1;
    localparam logic [1:0] OP_S32 = 2'd2;
    localparam logic [1:0] OP_S64 = 2'd3;

    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } leb_cmd_t;

    typedef struct packed {
        logic done;
    } leb_status_t;

endpackage

// ----- src/leb128_encoder_top.sv -----
// Top level of the LEB128 encoder: controller plus datapath.
// Takes one 64-bit word with an opcode (unsigned32, unsigned64, signed32,
// signed64) and emits its LEB128 encoding one byte per output word, least
// significant group first, last marking the final byte. One word is worked
// at a time: after the load, the 7-bit shift of the single value register
// emits one byte per cycle while the output is not stalled.
module leb128_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic [1:0]  opcode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    leb_pkg::leb_cmd_t    cmd;
    leb_pkg::leb_status_t status;

    leb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    leb_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .opcode   (opcode),
        .cmd      (cmd),
        .status   (status),
        .out_byte (out_byte),
        .last     (last)
    );

    a_load_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no output after load");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while emitting");

    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("encoding cut short");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after last byte");

    a_cont_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte[7] == !last))
        else $error("continuation flag mismatch");

endmodule

// ----- src/leb_ctrl.sv -----
// Controller: load/emit sequencing for one word at a time.
module leb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  leb_pkg::leb_status_t status,
    output leb_pkg::leb_cmd_t   cmd
);

    leb_pkg::state_t state_reg;
    leb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= leb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = leb_pkg::ST_EMIT;
                end
            end
            leb_pkg::ST_EMIT:
            begin
                if (out_ready && status.done)
                begin
                    state_next = leb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = leb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            leb_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
        cmd.load  = in_valid && in_ready;
        cmd.shift = out_valid && out_ready;
    end

endmodule

// ----- src/leb_dp.sv -----
// Datapath: value shift register, sign state and byte counter.
module leb_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [leb_pkg::VALUE_W-1:0]   value,
    input  logic [1:0]                    opcode,
    input  leb_pkg::leb_cmd_t             cmd,
    output leb_pkg::leb_status_t          status,
    output logic [7:0]                    out_byte,
    output logic                          last
);

    logic [leb_pkg::VALUE_W-1:0] val_reg;
    logic [leb_pkg::VALUE_W-1:0] val_next;
    logic                        sgn_reg;
    logic                        sgn_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [leb_pkg::CNT_W-1:0]   cnt_reg;
    logic [leb_pkg::CNT_W-1:0]   cnt_next;

    logic [leb_pkg::VALUE_W-1:0] load_val;
    logic                        load_sgn;
    logic                        wide;
    logic [leb_pkg::VALUE_W-1:0] rest;
    logic [leb_pkg::GROUP_W-1:0] grp;
    logic                        done;

    always_comb
    begin
        load_sgn = opcode inside {leb_pkg::OP_S32, leb_pkg::OP_S64};
        wide     = opcode inside {leb_pkg::OP_U64, leb_pkg::OP_S64};
        if (wide)
        begin
            load_val = value;
        end
        else if (load_sgn)
        begin
            load_val = {{32{value[31]}}, value[31:0]};
        end
        else
        begin
            load_val = {32'd0, value[31:0]};
        end
    end

    always_comb
    begin
        grp  = val_reg[leb_pkg::GROUP_W-1:0];
        rest = {{leb_pkg::GROUP_W{neg_reg}}, val_reg[leb_pkg::VALUE_W-1:leb_pkg::GROUP_W]};
        if (sgn_reg)
        begin
            done = ((rest == '0) && !grp[6]) || ((rest == '1) && grp[6]);
        end
        else
        begin
            done = (rest == '0);
        end
        if (cnt_reg == leb_pkg::CNT_W'(leb_pkg::MAX_BYTES - 1))
        begin
            done = 1'b1;
        end
        status.done = done;
        out_byte    = {1'b0, grp} | (done ? 8'h00 : leb_pkg::CONT_BIT);
        last        = done;
    end

    always_comb
    begin
        val_next = val_reg;
        sgn_next = sgn_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            val_next = load_val;
            sgn_next = load_sgn;
            neg_next = load_sgn && load_val[leb_pkg::VALUE_W-1];
            cnt_next = '0;
        end
        else if (cmd.shift)
        begin
            val_next = rest;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sgn_reg <= sgn_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
